// ===== rtl/ctlb_pkg.sv =====
// shared widths, operation and status codes for the cursor text line buffer
package ctlb_pkg;

  localparam int unsigned DEFAULT_CAPACITY = 1024;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned LEN_W  = 11;
  localparam int unsigned ST_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LEFT   = 3'd0,
    OP_RIGHT  = 3'd1,
    OP_BACK   = 3'd2,
    OP_INSERT = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE     = 2'd0,
    ST_BOUNDARY = 2'd1,
    ST_FULL     = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

endpackage

// ===== rtl/cursor_text_line_buffer.sv =====
// Line-editing text buffer with a cursor, held as a gap buffer in one single-port
// character RAM of CAPACITY bytes: text left of the cursor sits at the bottom of the
// RAM, text right of it at the top. Backspace, insert, and every operation that hits a
// boundary, a full buffer or an out-of-range index finish straight from the idle state;
// a cursor move or a successful read also passes through the wait state, because the
// single RAM port has a registered read: a move first reads one end of the gap and
// then writes the other. Each transaction gives one result, held in an output register;
// the next is taken in the idle state once that register is empty or being emptied.
// The RAM is never cleared: a read only reaches positions that hold text.
module cursor_text_line_buffer
  import ctlb_pkg::*;
#(
  parameter int unsigned CAPACITY = ctlb_pkg::DEFAULT_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ctlb_pkg::OP_W-1:0]   in_operation,
  input  logic [ctlb_pkg::CHAR_W-1:0] in_character,
  input  logic [ctlb_pkg::IDX_W-1:0]  in_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ctlb_pkg::CHAR_W-1:0] out_read_character,
  output logic [ctlb_pkg::LEN_W-1:0]  out_text_length,
  output logic [ctlb_pkg::LEN_W-1:0]  out_cursor_position,
  output logic [ctlb_pkg::ST_W-1:0]   out_status
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = (CW > IDX_W) ? CW : IDX_W;
  localparam int unsigned LW = (CW > LEN_W) ? CW : LEN_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WAIT = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      left_r, left_nxt;
  logic [CW-1:0]      right_r, right_nxt;
  logic [AW-1:0]      wr_addr_r, wr_addr_nxt;
  logic               move_r, move_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic [LEN_W-1:0]   out_len_r, out_len_nxt;
  logic [LEN_W-1:0]   out_cur_r, out_cur_nxt;
  logic [ST_W-1:0]    out_st_r, out_st_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [CHAR_W-1:0]  ram_wdata;
  logic [CHAR_W-1:0]  ram_rdata;

  logic [CW-1:0]      total;
  logic [IW-1:0]      idx_ext, left_ext, total_ext, rd_hi_addr;
  logic [LW-1:0]      len_ext, cur_ext;
  logic               accept;
  logic               finish;
  status_t            st;

  assign in_ready   = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept     = in_valid && in_ready;
  assign total      = left_r + right_r;
  assign idx_ext    = IW'(in_index);
  assign left_ext   = IW'(left_r);
  assign total_ext  = IW'(total);
  // upper segment address: capacity - right + (idx - left), always below capacity
  assign rd_hi_addr = IW'(CAP_C) - IW'(right_r) + (idx_ext - left_ext);

  always_comb begin
    state_nxt     = state_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    wr_addr_nxt   = wr_addr_r;
    move_nxt      = move_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_len_nxt   = out_len_r;
    out_cur_nxt   = out_cur_r;
    out_st_nxt    = out_st_r;
    ram_we        = 1'b0;
    ram_addr      = left_r[AW-1:0];
    ram_wdata     = in_character;
    finish        = 1'b0;
    st            = ST_DONE;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (op_t'(in_operation))
            OP_LEFT: begin
              if (left_r != '0) begin
                ram_addr    = AW'(left_r - 1'b1);
                wr_addr_nxt = AW'(CAP_C - right_r - 1'b1);
                left_nxt    = left_r - 1'b1;
                right_nxt   = right_r + 1'b1;
                move_nxt    = 1'b1;
                state_nxt   = S_WAIT;
              end else begin
                finish = 1'b1;
                st     = ST_BOUNDARY;
              end
            end
            OP_RIGHT: begin
              if (right_r != '0) begin
                ram_addr    = AW'(CAP_C - right_r);
                wr_addr_nxt = AW'(left_r);
                left_nxt    = left_r + 1'b1;
                right_nxt   = right_r - 1'b1;
                move_nxt    = 1'b1;
                state_nxt   = S_WAIT;
              end else begin
                finish = 1'b1;
                st     = ST_BOUNDARY;
              end
            end
            OP_BACK: begin
              finish = 1'b1;
              if (left_r != '0) begin
                left_nxt = left_r - 1'b1;
              end else begin
                st = ST_BOUNDARY;
              end
            end
            OP_INSERT: begin
              finish = 1'b1;
              if (total != CAP_C) begin
                ram_we   = 1'b1;
                ram_addr = AW'(left_r);
                left_nxt = left_r + 1'b1;
              end else begin
                st = ST_FULL;
              end
            end
            OP_READ: begin
              if (idx_ext < left_ext) begin
                ram_addr  = AW'(in_index);
                move_nxt  = 1'b0;
                state_nxt = S_WAIT;
              end else if (idx_ext < total_ext) begin
                ram_addr  = rd_hi_addr[AW-1:0];
                move_nxt  = 1'b0;
                state_nxt = S_WAIT;
              end else begin
                finish = 1'b1;
                st     = ST_RANGE;
              end
            end
            default: begin
              finish = 1'b1;
              st     = ST_BOUNDARY;
            end
          endcase
        end
      end
      S_WAIT: begin
        // ram data is valid now; a move writes it to the other end of the gap
        if (move_r) begin
          ram_we    = 1'b1;
          ram_addr  = wr_addr_r;
          ram_wdata = ram_rdata;
        end
        finish    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    len_ext = LW'(left_nxt + right_nxt);
    cur_ext = LW'(left_nxt);
    if (finish) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = (state_r == S_WAIT && !move_r) ? ram_rdata : '0;
      out_len_nxt   = len_ext[LEN_W-1:0];
      out_cur_nxt   = cur_ext[LEN_W-1:0];
      out_st_nxt    = st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      left_r      <= '0;
      right_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r  <= wr_addr_nxt;
    move_r     <= move_nxt;
    out_char_r <= out_char_nxt;
    out_len_r  <= out_len_nxt;
    out_cur_r  <= out_cur_nxt;
    out_st_r   <= out_st_nxt;
  end

  ctlb_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(CAPACITY)
  ) u_char_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign out_valid           = out_valid_r;
  assign out_read_character  = out_char_r;
  assign out_text_length     = out_len_r;
  assign out_cursor_position = out_cur_r;
  assign out_status          = out_st_r;

endmodule

// ===== rtl/ctlb_ram.sv =====
// generic single-port ram with registered read
module ctlb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/ctlb_checker.sv =====
// port-level checks for the cursor text line buffer, bound to the top level
module ctlb_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ctlb_pkg::CHAR_W-1:0] out_read_character,
  input logic [ctlb_pkg::LEN_W-1:0]  out_text_length,
  input logic [ctlb_pkg::LEN_W-1:0]  out_cursor_position,
  input logic [ctlb_pkg::ST_W-1:0]   out_status
);
  import ctlb_pkg::*;

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_text_length)
      && $stable(out_cursor_position) && $stable(out_status)
      && $stable(out_read_character))
    else $error("result changed while stalled");

  // an out-of-range read returns no character
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_RANGE |-> out_read_character == '0)
    else $error("out-of-range read returned data");

  // cursor never sits past the end of the text
  a_cursor_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cursor_position <= out_text_length)
    else $error("cursor beyond text length");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a transaction is accepted only while the result slot is empty or being emptied
  a_accept_slot: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("transaction accepted while result slot blocked");

endmodule

bind cursor_text_line_buffer ctlb_checker u_ctlb_checker (.*);
